### rtl/core/psu_pkg.sv
`timescale 1ns / 1ps

package psu_pkg;

    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_WIDTH    = 1'd0,
        REG_PIXEL_FORMAT = 1'd1
    } t_reg_index;

    typedef enum logic [1:0] {
        FMT_INDEXED = 2'd0,
        FMT_RGB     = 2'd1,
        FMT_RGBA    = 2'd2,
        FMT_RGBA_X  = 2'd3
    } t_pixel_format;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4,
        FLT_BAD   = 3'd5
    } t_filter;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] FLT_MAX_CODE = 8'd4;

endpackage

### rtl/core/png_scanline_unfilter_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_byte, i_image_start
// out       output     o_out_valid / i_out_ready  o_out_byte, o_bad_filter, o_row_done, o_last
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// one input byte per cycle while the output is not stalled; a byte enters a register
// stage whose row store read (one read port, registered) lands with it, and the
// result passes on to the output register. rgb pixels give two output transactions
// on their third byte, so output bandwidth sets the rate there.
// synchronous active-low reset clears row state; the row store is not cleared.
// a stalled output holds the stage register and then the input.
module png_scanline_unfilter_unit
    import psu_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_image_start,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_bad_filter,
    output logic                  o_row_done,
    output logic                  o_last
);

    localparam int unsigned DEPTH = MAX_WIDTH * 4;
    localparam int unsigned POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned RB_W  = POS_W + 1;

    // configuration
    logic [CFG_DATA_W-1:0] r_row_width;
    t_pixel_format         r_pixel_format;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width    <= CFG_DATA_W'(1);
            r_pixel_format <= FMT_RGBA;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_ROW_WIDTH:    r_row_width <= i_cfg_data;
                REG_PIXEL_FORMAT: r_pixel_format <= t_pixel_format'(i_cfg_data[1:0]);
                default: begin
                end
            endcase
        end
    end

    // row geometry
    logic [2:0]      bpp;
    logic [RB_W-1:0] w_clamp;
    logic [RB_W-1:0] row_bytes;
    logic [RB_W-1:0] rb_m1;

    always_comb begin
        case (r_pixel_format)
            FMT_INDEXED: bpp = 3'd1;
            FMT_RGB:     bpp = 3'd3;
            default:     bpp = 3'd4;
        endcase
        if (r_row_width == '0) begin
            w_clamp = RB_W'(1);
        end else if (32'(r_row_width) > 32'(MAX_WIDTH)) begin
            w_clamp = RB_W'(MAX_WIDTH);
        end else begin
            w_clamp = RB_W'(r_row_width);
        end
        case (r_pixel_format)
            FMT_INDEXED: row_bytes = w_clamp;
            FMT_RGB:     row_bytes = (w_clamp << 1) + w_clamp;
            default:     row_bytes = w_clamp << 2;
        endcase
        rb_m1 = row_bytes - RB_W'(1);
    end

    // row control state
    logic [POS_W-1:0] r_pos;
    logic [1:0]       r_ph;
    logic             r_expect;
    logic             r_first;
    t_filter          r_filt;

    logic             in_acc;
    logic             is_filter;
    logic             first_eff;
    logic [POS_W-1:0] pos_eff;
    logic [1:0]       ph_eff;
    logic             end_row;
    logic             alpha;
    t_filter          new_filt;

    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        is_filter = i_image_start || r_expect;
        first_eff = i_image_start || r_first;
        pos_eff   = ({1'b0, r_pos} >= row_bytes) ? rb_m1[POS_W-1:0] : r_pos;
        ph_eff    = ({1'b0, r_ph} >= bpp) ? 2'd0 : r_ph;
        end_row   = ({1'b0, pos_eff} == rb_m1);
        alpha     = (r_pixel_format == FMT_RGB) && (ph_eff == 2'd2);
        new_filt  = (i_in_byte > FLT_MAX_CODE) ? FLT_BAD : t_filter'(i_in_byte[2:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_ph     <= '0;
            r_expect <= 1'b1;
            r_first  <= 1'b1;
            r_filt   <= FLT_NONE;
        end else if (in_acc) begin
            if (is_filter) begin
                r_filt   <= new_filt;
                r_expect <= 1'b0;
                r_first  <= first_eff;
                r_pos    <= '0;
                r_ph     <= '0;
            end else if (end_row) begin
                r_expect <= 1'b1;
                r_first  <= 1'b0;
                r_pos    <= '0;
                r_ph     <= '0;
            end else begin
                r_pos <= pos_eff + 1'b1;
                r_ph  <= ({1'b0, ph_eff} + 3'd1 >= bpp) ? 2'd0 : ph_eff + 2'd1;
            end
        end
    end

    // stage register
    logic             r_sv;
    logic             r_s_filter;
    logic [7:0]       r_s_x;
    logic [1:0]       r_s_ph;
    logic [POS_W-1:0] r_s_pos;
    logic             r_s_end;
    logic             r_s_alpha;
    logic             r_s_first;
    t_filter          r_s_filt;

    logic out_free;
    logic s_adv;

    assign s_adv      = r_sv && (r_s_filter || out_free);
    assign o_in_ready = !r_sv || s_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (in_acc) begin
            r_sv <= 1'b1;
        end else if (s_adv) begin
            r_sv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s_filter <= is_filter;
            r_s_x      <= i_in_byte;
            r_s_ph     <= ph_eff;
            r_s_pos    <= pos_eff;
            r_s_end    <= end_row;
            r_s_alpha  <= alpha;
            r_s_first  <= r_first;
            r_s_filt   <= r_filt;
        end
    end

    // previous row store
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_mem_rd;
    logic [7:0] v;
    logic       mem_we;

    assign mem_we = s_adv && !r_s_filter;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_s_pos] <= v;
        end
        if (in_acc && !is_filter) begin
            r_mem_rd <= r_mem[pos_eff];
        end
    end

    // reconstruction
    logic [7:0]        r_left   [4];
    logic [7:0]        r_upleft [4];
    logic [7:0]        a;
    logic [7:0]        b;
    logic [7:0]        c;
    logic [8:0]        avg_sum;
    logic signed [9:0] p;
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    logic [7:0]        pred;

    always_comb begin
        a       = r_left[r_s_ph];
        c       = r_upleft[r_s_ph];
        b       = r_s_first ? 8'd0 : r_mem_rd;
        avg_sum = {1'b0, a} + {1'b0, b};
        p       = $signed({2'b0, a}) + $signed({2'b0, b}) - $signed({2'b0, c});
        da      = p - $signed({2'b0, a});
        db      = p - $signed({2'b0, b});
        dc      = p - $signed({2'b0, c});
        pa      = (da < 0) ? -da : da;
        pb      = (db < 0) ? -db : db;
        pc      = (dc < 0) ? -dc : dc;
        if (pa <= pb && pa <= pc) begin
            pred = a;
        end else if (pb <= pc) begin
            pred = b;
        end else begin
            pred = c;
        end
        case (r_s_filt)
            FLT_NONE:  v = r_s_x;
            FLT_SUB:   v = r_s_x + a;
            FLT_UP:    v = r_s_x + b;
            FLT_AVG:   v = r_s_x + avg_sum[8:1];
            FLT_PAETH: v = r_s_x + pred;
            default:   v = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_left[i]   <= '0;
                r_upleft[i] <= '0;
            end
        end else if (s_adv) begin
            if (r_s_filter) begin
                for (int i = 0; i < 4; i++) begin
                    r_left[i]   <= '0;
                    r_upleft[i] <= '0;
                end
            end else begin
                r_left[r_s_ph]   <= v;
                r_upleft[r_s_ph] <= b;
            end
        end
    end

    // output register with pending alpha
    logic       r_ov;
    logic [7:0] r_obyte;
    logic       r_obad;
    logic       r_odone;
    logic       r_olast;
    logic       r_pend;
    logic       r_pend_done;
    logic       out_load;

    assign out_free = !r_ov || (i_out_ready && !r_pend);
    assign out_load = s_adv && !r_s_filter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) begin
                if (r_pend) begin
                    r_pend <= 1'b0;
                end else begin
                    r_ov <= 1'b0;
                end
            end
            if (out_load) begin
                r_ov   <= 1'b1;
                r_pend <= r_s_alpha;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_obyte     <= v;
            r_obad      <= (r_s_filt == FLT_BAD);
            r_odone     <= r_s_end && !r_s_alpha;
            r_olast     <= !r_s_alpha;
            r_pend_done <= r_s_end;
        end else if (r_ov && i_out_ready && r_pend) begin
            r_obyte <= ALPHA_OPAQUE;
            r_obad  <= 1'b0;
            r_odone <= r_pend_done;
            r_olast <= 1'b1;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_byte   = r_obyte;
    assign o_bad_filter = r_obad;
    assign o_row_done   = r_odone;
    assign o_last       = r_olast;

    a_pend_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_ov)
        else $error("alpha pending without a held result");

    a_alpha_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> (o_out_valid && o_out_byte == ALPHA_OPAQUE))
        else $error("inserted alpha did not follow");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_filter) |-> (o_out_byte == 8'd0))
        else $error("bad filter transaction carries data");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_row_done) |-> o_last)
        else $error("row end before last transaction of a byte");

endmodule

### bench/png_scanline_unfilter_unit_tb.sv
`timescale 1ns / 1ps

module png_scanline_unfilter_unit_tb;
    import psu_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int MAX_W        = 4096;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = 10;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       row_done;
        logic       last;
    } out_txn_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_in_byte;
    logic                  i_image_start;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_bad_filter;
    logic                  o_row_done;
    logic                  o_last;

    png_scanline_unfilter_unit #(
        .MAX_WIDTH(MAX_W)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_image_start(i_image_start),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_bad_filter (o_bad_filter),
        .o_row_done   (o_row_done),
        .o_last       (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow of the unfilter state
    logic [12:0]   cfg_row_width = 13'd1;
    t_pixel_format cfg_format    = FMT_RGBA;
    bit [7:0]      row_mem [MAX_W * 4];
    bit [7:0]      left_px [4];
    bit [7:0]      up_left_px [4];
    int unsigned   row_pos       = 0;
    int unsigned   px_phase      = 0;
    bit            want_filter   = 1'b1;
    bit            top_row       = 1'b1;
    t_filter       cur_filter    = FLT_NONE;

    out_txn_t expected_bytes [$];

    int mismatches   = 0;
    int in_count     = 0;
    int out_count    = 0;
    int rows_seen    = 0;
    int bad_rows     = 0;
    int sent_items   = 0;
    int in_idle_pct  = 0;
    int out_stall_pct = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    function automatic int unsigned pixel_bytes(input t_pixel_format fmt);
        case (fmt)
            FMT_INDEXED: return 1;
            FMT_RGB:     return 3;
            default:     return 4;
        endcase
    endfunction

    function automatic int unsigned row_bytes(input logic [12:0] width, input t_pixel_format fmt);
        int unsigned w;
        w = (width == 0) ? 1 : ((width > MAX_W) ? MAX_W : width);
        return w * pixel_bytes(fmt);
    endfunction

    function automatic logic [7:0] rebuild_sample(input t_filter f, input logic [7:0] x,
                                                  input logic [7:0] a, input logic [7:0] b,
                                                  input logic [7:0] c);
        int ia, ib, ic, p, pa, pb, pc;
        logic [7:0] pred;
        ia = a;
        ib = b;
        ic = c;
        case (f)
            FLT_NONE: return x;
            FLT_SUB:  return x + a;
            FLT_UP:   return x + b;
            FLT_AVG:  return x + 8'((ia + ib) / 2);
            FLT_PAETH: begin
                p  = ia + ib - ic;
                pa = (p > ia) ? p - ia : ia - p;
                pb = (p > ib) ? p - ib : ib - p;
                pc = (p > ic) ? p - ic : ic - p;
                if (pa <= pb && pa <= pc) pred = a;
                else if (pb <= pc) pred = b;
                else pred = c;
                return x + pred;
            end
            default: return 8'h00;
        endcase
    endfunction

    task automatic clear_row_state();
        for (int i = 0; i < 4; i++) begin
            left_px[i]    = 8'h00;
            up_left_px[i] = 8'h00;
        end
        row_pos  = 0;
        px_phase = 0;
    endtask

    task automatic unfilter_in_byte(input logic [7:0] x, input logic start);
        int unsigned bpp, len, pos, ph;
        logic [7:0] a, b, c, v;
        logic row_end, alpha;
        out_txn_t t;
        in_count++;
        bpp = pixel_bytes(cfg_format);
        len = row_bytes(cfg_row_width, cfg_format);
        if (start) begin
            top_row     = 1'b1;
            want_filter = 1'b1;
        end
        if (want_filter) begin
            cur_filter  = (x > FLT_MAX_CODE) ? FLT_BAD : t_filter'(x[2:0]);
            want_filter = 1'b0;
            clear_row_state();
            rows_seen++;
            if (cur_filter == FLT_BAD) bad_rows++;
            return;
        end
        pos = (row_pos >= len) ? len - 1 : row_pos;
        ph  = (px_phase >= bpp) ? 0 : px_phase;
        a = left_px[ph];
        c = up_left_px[ph];
        b = top_row ? 8'h00 : row_mem[pos];
        v = rebuild_sample(cur_filter, x, a, b, c);
        left_px[ph]    = v;
        up_left_px[ph] = b;
        row_mem[pos]   = v;
        row_end = (pos + 1 >= len);
        alpha   = (cfg_format == FMT_RGB) && (ph == 2);
        t.data     = v;
        t.bad      = (cur_filter == FLT_BAD);
        t.row_done = row_end && !alpha;
        t.last     = !alpha;
        expected_bytes.push_back(t);
        if (alpha) begin
            t.data     = ALPHA_OPAQUE;
            t.bad      = 1'b0;
            t.row_done = row_end;
            t.last     = 1'b1;
            expected_bytes.push_back(t);
        end
        if (row_end) begin
            want_filter = 1'b1;
            top_row     = 1'b0;
            clear_row_state();
        end else begin
            row_pos  = pos + 1;
            px_phase = (ph + 1 >= bpp) ? 0 : ph + 1;
        end
    endtask

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endtask

    task automatic check_out_byte();
        out_txn_t e;
        out_count++;
        if (expected_bytes.size() == 0) begin
            log_mismatch($sformatf("unexpected output transaction, byte %02h", o_out_byte));
            return;
        end
        e = expected_bytes.pop_front();
        if (o_out_byte !== e.data || o_bad_filter !== e.bad || o_row_done !== e.row_done
                || o_last !== e.last) begin
            log_mismatch($sformatf(
                "output %0d: expected byte %02h bad %b done %b last %b, got %02h %b %b %b",
                out_count, e.data, e.bad, e.row_done, e.last,
                o_out_byte, o_bad_filter, o_row_done, o_last));
        end
    endtask

    // outputs are checked before the new input is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_out_byte();
            if (i_in_valid && o_in_ready) unfilter_in_byte(i_in_byte, i_image_start);
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic start);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_byte     <= value;
        i_image_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
        sent_items++;
    endtask

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] random_filter();
        if ($urandom_range(9) == 0) return 8'($urandom_range(255, 5));
        return 8'($urandom_range(4));
    endfunction

    task automatic send_samples(input int n);
        repeat (n) send_byte(pick_sample(), 1'b0);
    endtask

    task automatic send_row(input logic [7:0] filt, input logic start, input int n);
        send_byte(filt, start);
        send_samples(n);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [CFG_DATA_W-1:0] value);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ROW_WIDTH) cfg_row_width = value;
        else cfg_format = t_pixel_format'(value[1:0]);
    endtask

    task automatic set_config(input int width, input t_pixel_format fmt);
        write_reg(REG_ROW_WIDTH, CFG_DATA_W'(width));
        write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
    endtask

    task automatic test_reset_config();
        send_row(FLT_NONE, 1'b1, 4);
        send_row(FLT_UP, 1'b0, 4);
        send_row(FLT_PAETH, 1'b0, 4);
    endtask

    task automatic test_filter_rules();
        set_config(3, FMT_INDEXED);
        send_row(FLT_NONE, 1'b1, 3);
        send_row(FLT_SUB, 1'b0, 3);
        send_row(FLT_UP, 1'b0, 3);
        send_row(FLT_AVG, 1'b0, 3);
        send_row(FLT_PAETH, 1'b0, 3);
        send_row(8'd5, 1'b0, 3);
        send_row(8'hFF, 1'b0, 3);
        send_row(FLT_PAETH, 1'b0, 3);
    endtask

    task automatic test_rgb_alpha();
        set_config(2, FMT_RGB);
        send_row(FLT_SUB, 1'b1, 6);
        send_row(FLT_PAETH, 1'b0, 6);
        send_row(8'd7, 1'b0, 6);
        send_row(FLT_UP, 1'b0, 6);
        send_row(FLT_AVG, 1'b0, 6);
    endtask

    task automatic test_width_limits();
        set_config(0, FMT_RGBA_X);
        send_row(FLT_SUB, 1'b1, 4);
        send_row(FLT_PAETH, 1'b0, 4);
        set_config(8191, FMT_INDEXED);
        send_row(FLT_SUB, 1'b1, 40);
        send_row(FLT_AVG, 1'b0, 40);
    endtask

    task automatic test_image_restart();
        set_config(2, FMT_RGBA);
        send_row(FLT_SUB, 1'b1, 3);
        send_row(FLT_PAETH, 1'b1, 8);
        send_row(FLT_UP, 1'b0, 8);
        send_row(8'd200, 1'b1, 8);
        send_row(FLT_AVG, 1'b0, 8);
    endtask

    task automatic test_midrow_config();
        // grow the row and switch to rgb in the middle of the first row
        set_config(3, FMT_RGBA);
        send_row(FLT_AVG, 1'b1, 6);
        set_config(5, FMT_RGB);
        send_samples(9);
        send_row(FLT_PAETH, 1'b0, 15);
        // shrink below the current position
        set_config(4, FMT_RGB);
        send_row(FLT_SUB, 1'b1, 5);
        set_config(4, FMT_INDEXED);
        send_samples(1);
        send_row(FLT_UP, 1'b0, 4);
    endtask

    task automatic test_output_hold();
        set_config(16, FMT_RGB);
        hold_left = HOLD_CYCLES;
        send_row(FLT_SUB, 1'b1, 48);
        send_row(FLT_PAETH, 1'b0, 48);
    endtask

    task automatic test_random_images();
        int idle_mix [4];
        int stall_mix [4];
        int goal, w, len, n;
        logic restart;
        idle_mix  = '{0, 69, 0, 29};
        stall_mix = '{0, 0, 69, 29};
        for (int p = 0; p < 4; p++) begin
            in_idle_pct   = idle_mix[p];
            out_stall_pct = stall_mix[p];
            goal = sent_items + RANDOM_ITEMS / 4;
            while (sent_items < goal) begin
                case ($urandom_range(19))
                    0:       w = $urandom_range(128, 41);
                    1, 2, 3: w = $urandom_range(40, 7);
                    4:       w = 0;
                    default: w = $urandom_range(6, 1);
                endcase
                set_config(w, t_pixel_format'(2'($urandom_range(3))));
                len = row_bytes(cfg_row_width, cfg_format);
                restart = 1'b1;
                repeat ($urandom_range(5, 1)) begin
                    // some rows are cut short, then restarted or left misaligned
                    n = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : len;
                    send_row(random_filter(), restart, n);
                    restart = (n < len) && ($urandom_range(1) == 1);
                end
            end
        end
        in_idle_pct   = 0;
        out_stall_pct = 0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_ROW_WIDTH;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_in_byte     <= 8'h00;
        i_image_start <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_config();
        test_filter_rules();
        test_rgb_alpha();
        test_width_limits();
        test_image_restart();
        test_midrow_config();
        test_output_hold();
        test_random_images();
        wait_drain();

        $display("%0d input and %0d output transactions over %0d rows, %0d with an unknown filter",
                 in_count, out_count, rows_seen, bad_rows);
        $display("all filter types, four pixel formats, widths 0 to 8191, restarts, mid-row %s",
                 "register changes, idle/stall mixes and a long output hold");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/psu_pkg.sv
rtl/core/png_scanline_unfilter_unit.sv
bench/png_scanline_unfilter_unit_tb.sv
